[rtl/core/lms_pkg.sv]
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and constants of the broken-line minimiser step core.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned CfgW       = 31;
  localparam int unsigned OpW        = 2;
  localparam int unsigned StepCountW = 9;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned FracW      = 16;
  localparam int unsigned MulAW      = 33;
  localparam int unsigned MulBW      = 32;
  localparam int unsigned ProdW      = 64;
  localparam int unsigned WideW      = 50;

  localparam logic [CfgW-1:0]         LipschitzRst = 31'd983040;
  localparam logic [CfgW-1:0]         InvTwiceRst  = 31'd2185;
  localparam logic [CfgW-1:0]         PrecisionRst = 31'd655;
  localparam logic signed [DataW-1:0] LeftEndRst   = 32'sd196608;
  localparam logic signed [DataW-1:0] RightEndRst  = 32'sd327680;

  typedef enum logic [OpW-1:0] {
    OpLoadA = 2'd0,
    OpStart = 2'd1,
    OpValue = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLipschitz = 3'd0,
    CfgInvTwice  = 3'd1,
    CfgPrecision = 3'd2,
    CfgLeftEnd   = 3'd3,
    CfgRightEnd  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [OpW-1:0]          opcode;
    logic signed [DataW-1:0] func_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] next_point;
    logic signed [DataW-1:0] lower_bound;
    logic                    point_valid;
    logic                    done_res;
    logic                    table_full;
    logic [StepCountW-1:0]   step_count;
  } res_item_t;

  typedef struct packed {
    logic wr_en;
    logic scan_start;
  } tbl_ctrl_t;

  typedef struct packed {
    logic scan_busy;
    logic scan_done;
  } tbl_stat_t;

endpackage

[rtl/core/lms_mul.sv]
// ----------------------------------------------------------------------------
// lms_mul
// Registered signed multiplier shared by bound, point and split arithmetic.
// ----------------------------------------------------------------------------
module lms_mul (
  input  logic                               clk_i,
  input  logic signed [lms_pkg::MulAW-1:0]   a_i,
  input  logic signed [lms_pkg::MulBW-1:0]   b_i,
  output logic signed [lms_pkg::ProdW-1:0]   p_o
);

  logic signed [lms_pkg::MulAW+lms_pkg::MulBW-1:0] prod;
  logic signed [lms_pkg::ProdW-1:0]                p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= prod[lms_pkg::ProdW-1:0];
  end

  assign p_o = p_q;

endmodule

[rtl/core/lms_cand_table.sv]
// ----------------------------------------------------------------------------
// lms_cand_table
// Candidate memory {live, point, bound} with one write port and a read port
// that sweeps the used entries, tracking the first live entry of lowest bound.
// ----------------------------------------------------------------------------
module lms_cand_table #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned DATA_W = 32,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lms_pkg::tbl_ctrl_t       ctrl_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic                     wr_live_i,
  input  logic signed [DATA_W-1:0] wr_point_i,
  input  logic signed [DATA_W-1:0] wr_bound_i,
  input  logic [CW-1:0]            used_i,
  output lms_pkg::tbl_stat_t       stat_o,
  output logic [AW-1:0]            best_idx_o,
  output logic signed [DATA_W-1:0] best_point_o,
  output logic signed [DATA_W-1:0] best_bound_o
);

  localparam int unsigned EntW = 2 * DATA_W + 1;

  logic [EntW-1:0]          mem_q [DEPTH];
  logic [EntW-1:0]          rd_data_q;
  logic                     scan_act_q;
  logic [AW-1:0]            scan_cnt_q;
  logic [CW-1:0]            used_q;
  logic                     rd_vld_q;
  logic                     rd_last_q;
  logic [AW-1:0]            rd_idx_q;
  logic                     best_vld_q;
  logic [AW-1:0]            best_idx_q;
  logic signed [DATA_W-1:0] best_point_q;
  logic signed [DATA_W-1:0] best_bound_q;

  logic                     rd_live;
  logic signed [DATA_W-1:0] rd_point;
  logic signed [DATA_W-1:0] rd_bound;
  logic                     issue_last;
  logic                     take;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= {wr_live_i, wr_point_i, wr_bound_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[scan_cnt_q];
  end

  assign rd_live  = rd_data_q[2*DATA_W];
  assign rd_point = rd_data_q[2*DATA_W-1:DATA_W];
  assign rd_bound = rd_data_q[DATA_W-1:0];

  assign issue_last = (CW'(scan_cnt_q) + CW'(1)) == used_q;
  assign take = rd_vld_q && rd_live && (!best_vld_q || (rd_bound < best_bound_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q <= 1'b0;
      scan_cnt_q <= '0;
      used_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= scan_act_q;
      rd_last_q <= scan_act_q && issue_last;
      if (ctrl_i.scan_start) begin
        scan_act_q <= 1'b1;
        scan_cnt_q <= '0;
        used_q     <= used_i;
        best_vld_q <= 1'b0;
      end else begin
        if (scan_act_q) begin
          scan_cnt_q <= scan_cnt_q + AW'(1);
          if (issue_last) begin
            scan_act_q <= 1'b0;
          end
        end
        if (take) begin
          best_vld_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_cnt_q;
    if (take) begin
      best_idx_q   <= rd_idx_q;
      best_point_q <= rd_point;
      best_bound_q <= rd_bound;
    end
  end

  assign stat_o.scan_busy = scan_act_q || rd_vld_q;
  assign stat_o.scan_done = rd_vld_q && rd_last_q;
  assign best_idx_o       = best_idx_q;
  assign best_point_o     = best_point_q;
  assign best_bound_o     = best_bound_q;

  // last entry of a sweep is always a fresh live split
  a_best_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.scan_done |=> best_vld_q)
    else $error("sweep ended without a live candidate");

  a_no_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr_en |-> !scan_act_q)
    else $error("table write during sweep");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.scan_start |-> !stat_o.scan_busy)
    else $error("sweep restarted while busy");

endmodule

[rtl/core/lipschitz_minimizer_step_core.sv]
// ----------------------------------------------------------------------------
// lipschitz_minimizer_step_core
// One step of the broken-line Lipschitz minimiser per supplied function value.
//
// channel | ports                              | beat
// input   | start, busy, in_data_i             | taken when start && !busy
// result  | res_valid_o, res_data_o            | one-cycle strobe, no back-pressure
// config  | cfg_we_i, cfg_idx_i, cfg_wdata_i   | taken when cfg_we_i is high
//
// Load f(a), unused opcode and values after a halt: result 1 cycle after the
// beat, busy stays low. Start: result after StBound and StPoint. Refinement
// step: busy in StSplit, StWrHi, StScan and StTake, the StScan wait set by the
// one read port of the candidate memory sweeping all 2*steps + 2 entries.
// Reset needs no clearing pass; the fill count bounds every sweep.
// Results cannot be stalled; a new beat may be taken while one is shown.
// ----------------------------------------------------------------------------
module lipschitz_minimizer_step_core #(
  parameter int unsigned TABLE_DEPTH = 512,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  lms_pkg::in_item_t                      in_data_i,
  output logic                                   res_valid_o,
  output lms_pkg::res_item_t                     res_data_o,
  input  logic                                   cfg_we_i,
  input  logic [lms_pkg::CfgIdxW-1:0]            cfg_idx_i,
  input  logic [lms_pkg::DataW-1:0]              cfg_wdata_i
);

  localparam int unsigned SW     = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned STW    = $clog2(TABLE_DEPTH / 2 + 1);
  localparam int unsigned FullW  = CW + 1;
  localparam int unsigned OutW   = lms_pkg::DataW;
  localparam int unsigned StOutW = lms_pkg::StepCountW;
  localparam int unsigned WideW  = lms_pkg::WideW;
  localparam int unsigned ProdW  = lms_pkg::ProdW;
  localparam int unsigned FracW  = lms_pkg::FracW;
  localparam int unsigned MulAW  = lms_pkg::MulAW;
  localparam int unsigned MulBW  = lms_pkg::MulBW;

  localparam logic signed [WideW-1:0] SatHi = (WideW'(1) <<< (SW - 1)) - WideW'(1);
  localparam logic signed [WideW-1:0] SatLo = ~SatHi;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StBound = 7'b0000010,
    StPoint = 7'b0000100,
    StSplit = 7'b0001000,
    StWrHi  = 7'b0010000,
    StScan  = 7'b0100000,
    StTake  = 7'b1000000
  } state_e;

  function automatic logic signed [SW-1:0] sat_f(input logic signed [WideW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SatHi) begin
      r = SatHi[SW-1:0];
    end else if (v < SatLo) begin
      r = SatLo[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic lms_pkg::res_item_t mk_res(input logic signed [SW-1:0] pt,
                                                input logic signed [SW-1:0] bd,
                                                input logic vld,
                                                input logic dn,
                                                input logic fl,
                                                input logic [STW-1:0] st);
    lms_pkg::res_item_t r;
    r.next_point  = OutW'(pt);
    r.lower_bound = OutW'(bd);
    r.point_valid = vld;
    r.done_res    = dn;
    r.table_full  = fl;
    r.step_count  = StOutW'(st);
    return r;
  endfunction

  // configuration
  logic [lms_pkg::CfgW-1:0]         lip_q;
  logic [lms_pkg::CfgW-1:0]         inv_q;
  logic [lms_pkg::CfgW-1:0]         prec_q;
  logic signed [lms_pkg::DataW-1:0] left_q;
  logic signed [lms_pkg::DataW-1:0] right_q;

  // search state
  state_e                           state_q, state_d;
  logic signed [lms_pkg::DataW-1:0] va_q, va_d;
  logic signed [lms_pkg::DataW-1:0] f_q, f_d;
  logic signed [SW-1:0]             cur_point_q, cur_point_d;
  logic signed [SW-1:0]             cur_bound_q, cur_bound_d;
  logic [STW-1:0]                   steps_q, steps_d;
  logic                             halted_q, halted_d;
  logic                             full_q, full_d;
  logic signed [SW-1:0]             hi_q, hi_d;
  logic signed [SW-1:0]             half_q, half_d;
  logic                             res_vld_q, res_vld_d;
  lms_pkg::res_item_t               res_q, res_d;

  lms_pkg::op_e                     op_in;
  logic                             accept;
  logic signed [lms_pkg::DataW-1:0] f_in;
  logic signed [32:0]               diff;
  logic                             diff_lt;
  logic                             no_room;
  logic signed [32:0]               span;
  logic signed [32:0]               sum_ab;
  logic signed [32:0]               sum_vf;
  logic signed [32:0]               diff_vf;
  logic signed [32:0]               sum_fb;
  logic signed [ProdW-FracW-2:0]    mprod;
  logic signed [ProdW-FracW-1:0]    xprod;
  logic signed [ProdW-FracW:0]      delta;
  logic signed [WideW-1:0]          m_wide;
  logic signed [WideW-1:0]          x_wide;
  logic signed [WideW-1:0]          lo_wide;
  logic signed [WideW-1:0]          hi_wide;
  logic signed [WideW-1:0]          half_wide;
  logic signed [SW-1:0]             x_sat;
  logic signed [SW-1:0]             half_sat;
  logic [AW-1:0]                    base;
  logic [CW-1:0]                    used;

  logic signed [MulAW-1:0]          mul_a;
  logic signed [MulBW-1:0]          mul_b;
  logic signed [ProdW-1:0]          prod_q;

  lms_pkg::tbl_ctrl_t               tbl_ctrl;
  lms_pkg::tbl_stat_t               tbl_stat;
  logic [AW-1:0]                    tbl_addr;
  logic                             tbl_live;
  logic signed [SW-1:0]             tbl_point;
  logic signed [SW-1:0]             tbl_bound;
  logic [AW-1:0]                    best_idx;
  logic signed [SW-1:0]             best_point;
  logic signed [SW-1:0]             best_bound;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign op_in  = lms_pkg::op_e'(in_data_i.opcode);
  assign f_in   = in_data_i.func_value;

  assign diff    = 33'(f_in) - 33'(cur_bound_q);
  assign diff_lt = diff < $signed({2'b00, prec_q});
  assign no_room = (FullW'({steps_q, 1'b0}) + FullW'(2)) > FullW'(TABLE_DEPTH);
  assign base    = AW'({steps_q, 1'b0});
  assign used    = CW'({steps_q, 1'b0}) + CW'(2);

  assign span    = 33'(left_q) - 33'(right_q);
  assign sum_ab  = 33'(left_q) + 33'(right_q);
  assign sum_vf  = 33'(va_q) + 33'(f_q);
  assign diff_vf = 33'(va_q) - 33'(f_q);
  assign sum_fb  = 33'(f_q) + 33'(cur_bound_q);

  assign mprod = prod_q[ProdW-1:FracW+1];
  assign xprod = prod_q[ProdW-1:FracW];
  assign delta = {1'b0, prod_q[ProdW-1:FracW]};

  assign m_wide    = WideW'(mprod) + WideW'(sum_vf >>> 1);
  assign x_wide    = WideW'(xprod) + WideW'(sum_ab >>> 1);
  assign lo_wide   = WideW'(cur_point_q) - WideW'(delta);
  assign hi_wide   = WideW'(cur_point_q) + WideW'(delta);
  assign half_wide = WideW'(sum_fb >>> 1);
  assign x_sat     = sat_f(x_wide);
  assign half_sat  = sat_f(half_wide);

  lms_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod_q)
  );

  lms_cand_table #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (SW)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tbl_ctrl),
    .wr_addr_i    (tbl_addr),
    .wr_live_i    (tbl_live),
    .wr_point_i   (tbl_point),
    .wr_bound_i   (tbl_bound),
    .used_i       (used),
    .stat_o       (tbl_stat),
    .best_idx_o   (best_idx),
    .best_point_o (best_point),
    .best_bound_o (best_bound)
  );

  always_comb begin
    state_d     = state_q;
    va_d        = va_q;
    f_d         = f_q;
    cur_point_d = cur_point_q;
    cur_bound_d = cur_bound_q;
    steps_d     = steps_q;
    halted_d    = halted_q;
    full_d      = full_q;
    hi_d        = hi_q;
    half_d      = half_q;
    res_vld_d   = 1'b0;
    res_d       = res_q;
    tbl_ctrl    = '0;
    tbl_addr    = base;
    tbl_live    = 1'b1;
    tbl_point   = sat_f(lo_wide);
    tbl_bound   = half_sat;
    mul_a       = diff;
    mul_b       = {1'b0, inv_q};

    unique case (state_q)
      StIdle: begin
        if (op_in == lms_pkg::OpStart) begin
          mul_a = span;
          mul_b = {1'b0, lip_q};
        end
        if (accept) begin
          unique case (op_in)
            lms_pkg::OpLoadA: begin
              va_d      = f_in;
              res_vld_d = 1'b1;
              res_d     = mk_res('0, '0, 1'b0, 1'b0, 1'b0, steps_q);
            end
            lms_pkg::OpStart: begin
              f_d     = f_in;
              state_d = StBound;
            end
            lms_pkg::OpValue: begin
              if (halted_q) begin
                res_vld_d = 1'b1;
                res_d     = mk_res(cur_point_q, cur_bound_q, 1'b1, !full_q, full_q, steps_q);
              end else if (diff_lt) begin
                halted_d  = 1'b1;
                full_d    = 1'b0;
                res_vld_d = 1'b1;
                res_d     = mk_res(cur_point_q, cur_bound_q, 1'b1, 1'b1, 1'b0, steps_q);
              end else if (no_room) begin
                halted_d  = 1'b1;
                full_d    = 1'b1;
                res_vld_d = 1'b1;
                res_d     = mk_res(cur_point_q, cur_bound_q, 1'b1, 1'b0, 1'b1, steps_q);
              end else begin
                f_d     = f_in;
                state_d = StSplit;
              end
            end
            default: begin
              res_vld_d = 1'b1;
              res_d     = mk_res('0, '0, 1'b0, 1'b0, 1'b0, steps_q);
            end
          endcase
        end
      end
      StBound: begin
        mul_a       = diff_vf;
        cur_bound_d = sat_f(m_wide);
        state_d     = StPoint;
      end
      StPoint: begin
        cur_point_d = x_sat;
        steps_d     = '0;
        halted_d    = 1'b0;
        full_d      = 1'b0;
        res_vld_d   = 1'b1;
        res_d       = mk_res(x_sat, cur_bound_q, 1'b1, 1'b0, 1'b0, '0);
        state_d     = StIdle;
      end
      StSplit: begin
        tbl_ctrl.wr_en = 1'b1;
        hi_d           = sat_f(hi_wide);
        half_d         = half_sat;
        state_d        = StWrHi;
      end
      StWrHi: begin
        tbl_ctrl.wr_en      = 1'b1;
        tbl_ctrl.scan_start = 1'b1;
        tbl_addr            = base + AW'(1);
        tbl_point           = hi_q;
        tbl_bound           = half_q;
        state_d             = StScan;
      end
      StScan: begin
        if (tbl_stat.scan_done) begin
          state_d = StTake;
        end
      end
      StTake: begin
        tbl_ctrl.wr_en = 1'b1;
        tbl_addr       = best_idx;
        tbl_live       = 1'b0;
        tbl_point      = best_point;
        tbl_bound      = best_bound;
        cur_point_d    = best_point;
        cur_bound_d    = best_bound;
        steps_d        = steps_q + STW'(1);
        res_vld_d      = 1'b1;
        res_d          = mk_res(best_point, best_bound, 1'b1, 1'b0, 1'b0, steps_q + STW'(1));
        state_d        = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lip_q       <= lms_pkg::LipschitzRst;
      inv_q       <= lms_pkg::InvTwiceRst;
      prec_q      <= lms_pkg::PrecisionRst;
      left_q      <= lms_pkg::LeftEndRst;
      right_q     <= lms_pkg::RightEndRst;
    end else if (cfg_we_i) begin
      unique case (lms_pkg::cfg_reg_e'(cfg_idx_i))
        lms_pkg::CfgLipschitz: lip_q   <= cfg_wdata_i[lms_pkg::CfgW-1:0];
        lms_pkg::CfgInvTwice:  inv_q   <= cfg_wdata_i[lms_pkg::CfgW-1:0];
        lms_pkg::CfgPrecision: prec_q  <= cfg_wdata_i[lms_pkg::CfgW-1:0];
        lms_pkg::CfgLeftEnd:   left_q  <= cfg_wdata_i;
        lms_pkg::CfgRightEnd:  right_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      va_q        <= '0;
      cur_point_q <= '0;
      cur_bound_q <= '0;
      steps_q     <= '0;
      halted_q    <= 1'b0;
      full_q      <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      va_q        <= va_d;
      cur_point_q <= cur_point_d;
      cur_bound_q <= cur_bound_d;
      steps_q     <= steps_d;
      halted_q    <= halted_d;
      full_q      <= full_d;
      res_vld_q   <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    hi_q   <= hi_d;
    half_q <= half_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_data_o  = res_q;

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (state_q == StIdle))
    else $error("result beat outside idle");

  a_load_a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.opcode == lms_pkg::OpLoadA))
      |=> (res_valid_o && !res_data_o.point_valid))
    else $error("load of f(a) gave no plain result");

  a_halt_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_q) |-> res_vld_q)
    else $error("halt without result beat");

  a_take_idle_tbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTake) |-> !tbl_stat.scan_busy)
    else $error("candidate taken before sweep ended");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the broken-line Lipschitz minimiser step core.
// Each accepted beat runs through a shadow of the search (candidate table,
// current point and bound, step count) to give the expected result, which
// is checked field by field against the strobed result in beat order.
// Directed runs cover the opcodes, restart, halts, configuration extremes
// and table overflow; randomised searches follow under several settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableDepth = 512;
  localparam int unsigned ClkPeriod  = 10;

  localparam int unsigned DataW      = lms_pkg::DataW;
  localparam int unsigned OpW        = lms_pkg::OpW;
  localparam int unsigned CfgW       = lms_pkg::CfgW;
  localparam int unsigned CfgIdxW    = lms_pkg::CfgIdxW;
  localparam int unsigned FracW      = lms_pkg::FracW;
  localparam int unsigned StepCountW = lms_pkg::StepCountW;

  localparam logic [OpW-1:0]          OpSpare   = 2'd3;
  localparam logic [CfgIdxW-1:0]      CfgSpare  = 3'd7;
  localparam logic signed [DataW-1:0] TopVal    = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] BottomVal = 32'sh8000_0000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  lms_pkg::in_item_t    in_data_i;
  logic                 res_valid_o;
  lms_pkg::res_item_t   res_data_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [DataW-1:0]     cfg_wdata_i;

  lipschitz_minimizer_step_core #(
    .TABLE_DEPTH(TableDepth),
    .VALUE_WIDTH(DataW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid_o),
    .res_data_o (res_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // shadow configuration
  longint lip_c, inv_c, prec_c, a_end, b_end;
  // shadow search state
  longint      fa_val, pt_now, bd_now;
  int unsigned n_steps;
  bit          stopped, stopped_full;
  longint      tab_pt [TableDepth];
  longint      tab_bd [TableDepth];
  bit          tab_live [TableDepth];

  lms_pkg::res_item_t due_results [$];
  lms_pkg::res_item_t want_beat;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned burst_left;

  function automatic logic signed [DataW-1:0] clamp32(input longint v);
    if (v > longint'(TopVal)) return TopVal;
    if (v < longint'(BottomVal)) return BottomVal;
    return v[DataW-1:0];
  endfunction

  // wide random magnitude, spread over bit lengths of up to 31 bits
  function automatic longint rand_mag();
    return longint'($urandom >> $urandom_range(1, 32));
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {1'b0, {(DataW-1){1'b1}}};
      2: return {1'b1, {(DataW-1){1'b0}}};
      3: return $urandom;
      default: return $urandom >> $urandom_range(1, 31);
    endcase
  endfunction

  function automatic lms_pkg::res_item_t minimiser_step(input lms_pkg::in_item_t beat);
    lms_pkg::res_item_t r;
    longint      fv, diff, delta, half_b, m_val, x_val;
    longint unsigned dprod;
    int unsigned lo_end;
    int          pick;
    r = '0;
    fv = longint'($signed(beat.func_value));
    case (beat.opcode)
      lms_pkg::OpLoadA: begin
        fa_val = fv;
      end
      lms_pkg::OpStart: begin
        m_val = (((a_end - b_end) * lip_c) >>> (FracW + 1)) + ((fa_val + fv) >>> 1);
        x_val = ((a_end + b_end) >>> 1) + (((fa_val - fv) * inv_c) >>> FracW);
        tab_live = '{default: 1'b0};
        n_steps = 0;
        stopped = 1'b0;
        stopped_full = 1'b0;
        pt_now = clamp32(x_val);
        bd_now = clamp32(m_val);
        r.next_point = pt_now[DataW-1:0];
        r.lower_bound = bd_now[DataW-1:0];
        r.point_valid = 1'b1;
      end
      lms_pkg::OpValue: begin
        diff = fv - bd_now;
        if (!stopped && diff < prec_c) begin
          stopped = 1'b1;
          stopped_full = 1'b0;
        end else if (!stopped && n_steps * 2 + 2 > TableDepth) begin
          stopped = 1'b1;
          stopped_full = 1'b1;
        end
        if (!stopped) begin
          dprod = $unsigned(diff) * $unsigned(inv_c);
          delta = longint'(dprod >> FracW);
          half_b = clamp32((fv + bd_now) >>> 1);
          lo_end = n_steps * 2;
          tab_pt[lo_end] = clamp32(pt_now - delta);
          tab_pt[lo_end + 1] = clamp32(pt_now + delta);
          tab_bd[lo_end] = half_b;
          tab_bd[lo_end + 1] = half_b;
          tab_live[lo_end] = 1'b1;
          tab_live[lo_end + 1] = 1'b1;
          pick = -1;
          for (int j = 0; j < int'(lo_end) + 2; j++) begin
            if (tab_live[j] && (pick < 0 || tab_bd[j] < tab_bd[pick])) pick = j;
          end
          pt_now = tab_pt[pick];
          bd_now = tab_bd[pick];
          tab_live[pick] = 1'b0;
          n_steps++;
        end
        r.next_point = pt_now[DataW-1:0];
        r.lower_bound = bd_now[DataW-1:0];
        r.point_valid = 1'b1;
        r.done_res = stopped && !stopped_full;
        r.table_full = stopped && stopped_full;
      end
      default: begin
      end
    endcase
    r.step_count = n_steps[StepCountW-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DataW-1:0] want_v,
                             input logic [DataW-1:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (res_valid_o) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing, actual %p",
                 $time, res_data_o);
      end else begin
        want_beat = due_results.pop_front();
        check_field("next_point", want_beat.next_point, res_data_o.next_point);
        check_field("lower_bound", want_beat.lower_bound, res_data_o.lower_bound);
        check_field("point_valid", DataW'(want_beat.point_valid),
                    DataW'(res_data_o.point_valid));
        check_field("done_res", DataW'(want_beat.done_res), DataW'(res_data_o.done_res));
        check_field("table_full", DataW'(want_beat.table_full),
                    DataW'(res_data_o.table_full));
        check_field("step_count", DataW'(want_beat.step_count),
                    DataW'(res_data_o.step_count));
      end
    end
  end

  // called and returns at a falling edge; start is left high for back-to-back beats
  task automatic send_item(input logic [OpW-1:0] op, input logic signed [DataW-1:0] fv);
    int unsigned       gap;
    lms_pkg::in_item_t beat;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(13, 90);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap != 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    beat.opcode = op;
    beat.func_value = fv;
    start = 1'b1;
    in_data_i = beat;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    due_results.push_back(minimiser_step(beat));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained(input int unsigned settle);
    start = 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      lms_pkg::CfgLipschitz: lip_c = longint'(val[CfgW-1:0]);
      lms_pkg::CfgInvTwice:  inv_c = longint'(val[CfgW-1:0]);
      lms_pkg::CfgPrecision: prec_c = longint'(val[CfgW-1:0]);
      lms_pkg::CfgLeftEnd:   a_end = longint'($signed(val));
      lms_pkg::CfgRightEnd:  b_end = longint'($signed(val));
      default: begin
      end
    endcase
  endtask

  task automatic write_all(input logic [DataW-1:0] lip, inv, prec, left, right);
    wait_drained(4);
    write_reg(lms_pkg::CfgLipschitz, lip);
    write_reg(lms_pkg::CfgInvTwice, inv);
    write_reg(lms_pkg::CfgPrecision, prec);
    write_reg(lms_pkg::CfgLeftEnd, left);
    write_reg(lms_pkg::CfgRightEnd, right);
  endtask

  // one search: f(a), f(b), then values mostly above the bound by at least the precision
  task automatic run_search(input int unsigned n_values, input bit noisy);
    longint margin;
    send_item(lms_pkg::OpLoadA, $urandom);
    send_item(lms_pkg::OpStart, $urandom);
    for (int unsigned i = 0; i < n_values; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        send_item(OpW'($urandom_range(0, 3)), $urandom);
      end else begin
        if ($urandom_range(0, 11) == 0) margin = prec_c - 1 - rand_mag();
        else margin = prec_c + rand_mag();
        send_item(lms_pkg::OpValue, clamp32(bd_now + margin));
      end
    end
    if ($urandom_range(0, 7) == 0) wait_drained($urandom_range(0, 6));
  endtask

  task automatic test_value_before_start();
    send_item(lms_pkg::OpValue, 32'sh4000_0000);
    send_item(lms_pkg::OpValue, TopVal);
    send_item(lms_pkg::OpValue, clamp32(bd_now + 32'sh0002_0000));
    send_item(lms_pkg::OpValue, BottomVal);
    send_item(lms_pkg::OpValue, 32'sh0000_1234);
    send_item(OpSpare, -32'sd1);
    send_item(lms_pkg::OpLoadA, BottomVal);
  endtask

  task automatic test_opcodes();
    send_item(lms_pkg::OpLoadA, 32'sh0003_0000);
    send_item(lms_pkg::OpStart, 32'sh0001_8000);
    send_item(lms_pkg::OpValue, clamp32(bd_now + 32'sh0005_0000));
    send_item(lms_pkg::OpValue, clamp32(bd_now + 32'sh0001_0000));
    send_item(lms_pkg::OpLoadA, -32'sh0002_0000);
    send_item(OpSpare, TopVal);
    send_item(lms_pkg::OpValue, clamp32(bd_now + 32'sh0000_8000));
    send_item(lms_pkg::OpStart, 32'sh0000_0000);
    send_item(lms_pkg::OpValue, clamp32(bd_now + 32'sh0000_1000));
    send_item(lms_pkg::OpValue, clamp32(bd_now + 100));
    send_item(lms_pkg::OpValue, TopVal);
  endtask

  task automatic test_config_extremes();
    write_all(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, BottomVal, TopVal);
    send_item(lms_pkg::OpLoadA, TopVal);
    send_item(lms_pkg::OpStart, BottomVal);
    send_item(lms_pkg::OpValue, TopVal);
    send_item(lms_pkg::OpValue, BottomVal);
    wait_drained(4);
    write_reg(CfgSpare, 32'hFFFF_FFFF);
    write_all(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, TopVal, BottomVal);
    send_item(lms_pkg::OpLoadA, BottomVal);
    send_item(lms_pkg::OpStart, TopVal);
    send_item(lms_pkg::OpValue, TopVal);
    send_item(lms_pkg::OpValue, TopVal);
  endtask

  task automatic test_table_full();
    write_all(DataW'(lms_pkg::LipschitzRst), DataW'(lms_pkg::InvTwiceRst), 32'h0,
              lms_pkg::LeftEndRst, lms_pkg::RightEndRst);
    send_item(lms_pkg::OpLoadA, 32'sh0002_0000);
    send_item(lms_pkg::OpStart, -32'sh0001_0000);
    for (int i = 0; i < int'(TableDepth) && !stopped; i++) begin
      send_item(lms_pkg::OpValue, clamp32(bd_now + rand_mag()));
    end
    send_item(lms_pkg::OpValue, BottomVal);
    send_item(lms_pkg::OpValue, TopVal);
  endtask

  task automatic test_random_searches();
    int unsigned target;
    for (int phase = 0; phase < 4; phase++) begin
      write_all(pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
      target = items_sent + 60;
      while (items_sent < target) run_search($urandom_range(1, 32), 1'b1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    lip_c = longint'(lms_pkg::LipschitzRst);
    inv_c = longint'(lms_pkg::InvTwiceRst);
    prec_c = longint'(lms_pkg::PrecisionRst);
    a_end = longint'(lms_pkg::LeftEndRst);
    b_end = longint'(lms_pkg::RightEndRst);
    fa_val = 0;
    pt_now = 0;
    bd_now = 0;
    n_steps = 0;
    stopped = 1'b0;
    stopped_full = 1'b0;
    tab_live = '{default: 1'b0};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_value_before_start();
    test_opcodes();
    test_config_extremes();
    test_table_full();
    test_random_searches();

    wait_drained(2 * TableDepth + 16);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[lipschitz_minimizer_step_core.f]
rtl/core/lms_pkg.sv
rtl/core/lms_mul.sv
rtl/core/lms_cand_table.sv
rtl/core/lipschitz_minimizer_step_core.sv
tb/tb_top.sv
